>>> src/dsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dsr_pkg;
    localparam int OperandWidth = 64;
    localparam int StatusWidth  = 2;
    localparam int SigWidth     = 54;
    localparam int RemWidth     = 56;
    localparam int IterCount    = 54;
    localparam int IterWidth    = 6;

    typedef enum logic [StatusWidth-1:0] {
        STATUS_NORMAL  = 2'd0,
        STATUS_CLAMPED = 2'd1,
        STATUS_INVALID = 2'd2
    } status_t;

    localparam logic [63:0] QuietNan = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] PosInf   = 64'h7FF0_0000_0000_0000;

    typedef struct packed {
        logic load;
        logic norm;
        logic step;
        logic finish;
    } dsr_cmd_t;

    typedef struct packed {
        logic special;
        logic norm_done;
        logic iter_done;
    } dsr_stat_t;
endpackage
`default_nettype wire

>>> src/dsr_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface dsr_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] operand_bits;
    modport source (output valid, output operand_bits, input ready);
    modport sink (input valid, input operand_bits, output ready);
endinterface

interface dsr_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] root_bits;
    logic [1:0]  status;
    modport source (output valid, output root_bits, output status, input ready);
    modport sink (input valid, input root_bits, input status, output ready);
endinterface
`default_nettype wire

>>> src/dsr_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module dsr_datapath (
    input  wire logic              clk,
    input  wire dsr_pkg::dsr_cmd_t cmd,
    input  wire logic [63:0]       operand_bits,
    output dsr_pkg::dsr_stat_t     stat,
    output logic [63:0]            root_bits,
    output logic [1:0]             status
);
    import dsr_pkg::*;

    logic [SigWidth-1:0]  m_reg;
    logic signed [12:0]   e_reg;
    logic [SigWidth-1:0]  q_reg;
    logic [RemWidth-1:0]  rem_reg;
    logic [IterWidth-1:0] cnt_reg;
    logic [63:0]          res_reg;
    logic [1:0]           st_reg;
    logic                 special_reg;

    logic [62:0] mag;
    logic        is_nan, is_clamp, is_inf;
    logic [RemWidth-1:0] rem_sh, trial;
    logic [SigWidth-2:0] mant;
    logic [SigWidth-1:0] mant_inc;
    logic signed [12:0]  f;
    logic [12:0]         bexp;
    logic                rnd;

    assign mag      = operand_bits[62:0];
    assign is_nan   = mag > PosInf[62:0];
    assign is_clamp = !is_nan && (operand_bits[63] || mag == '0);
    assign is_inf   = mag == PosInf[62:0];

    assign rem_sh = {rem_reg[RemWidth-3:0], m_reg[SigWidth-1:SigWidth-2]};
    assign trial  = {q_reg, 2'b01};

    assign mant     = q_reg[SigWidth-1:1];
    assign rnd      = q_reg[0] && (rem_reg != '0 || q_reg[1]);
    assign mant_inc = {1'b0, mant} + {{(SigWidth-1){1'b0}}, rnd};
    assign f        = (e_reg >>> 1) - 13'sd26 + (mant_inc[SigWidth-1] ? 13'sd1 : 13'sd0);
    assign bexp     = f + 13'sd1075;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            special_reg <= is_nan || is_clamp || is_inf;
            res_reg     <= is_nan ? QuietNan : (is_clamp ? 64'd0 : PosInf);
            st_reg      <= is_clamp ? STATUS_CLAMPED : STATUS_INVALID;
            if (operand_bits[62:52] == 11'd0)
            begin
                m_reg <= {2'b00, operand_bits[51:0]};
                e_reg <= -13'sd1074;
            end
            else
            begin
                m_reg <= {2'b01, operand_bits[51:0]};
                e_reg <= $signed({2'b00, operand_bits[62:52]}) - 13'sd1075;
            end
            q_reg   <= '0;
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.norm)
        begin
            if (!m_reg[52] && !m_reg[53])
            begin
                m_reg <= m_reg << 1;
                e_reg <= e_reg - 13'sd1;
            end
            else if (e_reg[0])
            begin
                m_reg <= m_reg << 1;
                e_reg <= e_reg - 13'sd1;
            end
        end
        else if (cmd.step)
        begin
            m_reg   <= m_reg << 2;
            cnt_reg <= cnt_reg + IterWidth'(1);
            if (rem_sh >= trial)
            begin
                rem_reg <= rem_sh - trial;
                q_reg   <= {q_reg[SigWidth-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                q_reg   <= {q_reg[SigWidth-2:0], 1'b0};
            end
        end
        else if (cmd.finish && !special_reg)
        begin
            res_reg <= {1'b0, bexp[10:0],
                        mant_inc[SigWidth-1] ? mant_inc[52:1] : mant_inc[51:0]};
            st_reg  <= STATUS_NORMAL;
        end
    end

    assign stat.special   = special_reg;
    assign stat.norm_done = (m_reg[52] || m_reg[53]) && !e_reg[0];
    assign stat.iter_done = cnt_reg == IterWidth'(IterCount - 1);
    assign root_bits      = res_reg;
    assign status         = st_reg;
endmodule
`default_nettype wire

>>> src/dsr_control.sv
`timescale 1ns / 1ps
`default_nettype none
module dsr_control (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    input  wire dsr_pkg::dsr_stat_t stat,
    output dsr_pkg::dsr_cmd_t       cmd
);
    import dsr_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_CHECK, S_NORM, S_ITER, S_FINISH, S_OUT} state_t;
    state_t state_reg;

    assign in_ready   = state_reg == S_IDLE;
    assign out_valid  = state_reg == S_OUT;
    assign cmd.load   = in_ready && in_valid;
    assign cmd.norm   = state_reg == S_NORM;
    assign cmd.step   = state_reg == S_ITER;
    assign cmd.finish = state_reg == S_FINISH;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
        begin
            case (state_reg)
                S_IDLE:   if (in_valid) state_reg <= S_CHECK;
                S_CHECK:  state_reg <= stat.special ? S_OUT : S_NORM;
                S_NORM:   if (stat.norm_done) state_reg <= S_ITER;
                S_ITER:   if (stat.iter_done) state_reg <= S_FINISH;
                S_FINISH: state_reg <= S_OUT;
                S_OUT:    if (out_ready) state_reg <= S_IDLE;
                default:  state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> src/double_square_root.sv
// Sequence: special operands go from the accept state through a check state
// straight to the result; normal operands also normalize (an odd exponent
// adds a shift; subnormals take one normalizing shift per cycle), iterate,
// round. Throughput: one operand at a time, none taken while a result waits;
// the 54-step restoring recurrence (one root bit per cycle) sets the rate.
// Reset: asynchronous active-low rst_n returns the controller to idle.
`timescale 1ns / 1ps
`default_nettype none
module double_square_root (
    input wire logic clk,
    input wire logic rst_n,
    dsr_in_if.sink   in_ch,
    dsr_out_if.source out_ch
);
    import dsr_pkg::*;

    dsr_cmd_t  cmd;
    dsr_stat_t stat;

    // Controller sequences load, normalize, iterate, round, present beat.
    dsr_control u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath holds operand, root, remainder and the result register.
    dsr_datapath u_dp (
        .clk          (clk),
        .cmd          (cmd),
        .operand_bits (in_ch.operand_bits),
        .stat         (stat),
        .root_bits    (out_ch.root_bits),
        .status       (out_ch.status)
    );
endmodule
`default_nettype wire

>>> src/dsr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module dsr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [63:0] root_bits,
    input wire logic [1:0]  status
);
    import dsr_pkg::*;

    a_never_three: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3) else $error("bad status");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("ready while result pending");
    a_clamp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_CLAMPED |-> root_bits == 64'd0)
        else $error("clamp not zero");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(root_bits))
        else $error("result dropped");
endmodule

bind double_square_root dsr_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .root_bits (out_ch.root_bits),
    .status    (out_ch.status)
);
`default_nettype wire

>>> tb/sv/double_square_root_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module double_square_root_tb;
    import dsr_pkg::*;

    localparam int NumRandom   = 1030;
    localparam int WatchLimit  = 20000;
    localparam int DrainCycles = 150;

    typedef struct packed {
        logic [63:0] root_bits;
        status_t     status;
    } root_result_t;

    // Directed stimulus: operand, whether the answer is typed in, and that answer.
    typedef struct packed {
        logic [63:0]  operand_bits;
        logic         fixed;
        root_result_t answer;
    } vector_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    dsr_in_if  in_ch ();
    dsr_out_if out_ch ();

    double_square_root dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    always #6 clk = ~clk;

    root_result_t pending_roots[$];
    int           fail_count = 0;
    int           beats_in = 0;
    int           beats_out = 0;
    int           special_count = 0;
    int           subnormal_count = 0;
    int           idle_cycles = 0;
    bit           stim_done = 0;
    bit           no_idle = 0;
    bit           hold_off = 0;

    // Correctly rounded binary64 root by restoring bit-pair recurrence.
    function automatic root_result_t predict_root(input logic [63:0] x);
        root_result_t res;
        logic [63:0]  mag;
        logic [10:0]  bexp;
        logic [53:0]  m;
        logic [53:0]  q;
        logic [57:0]  rem;
        logic [57:0]  trial;
        logic [52:0]  mant;
        logic [107:0] radicand;
        int           e;
        int           f;
        mag = {1'b0, x[62:0]};
        if (mag > PosInf)
        begin
            res.root_bits = QuietNan;
            res.status = STATUS_INVALID;
        end
        else if (x[63] || mag == 64'd0)
        begin
            res.root_bits = 64'd0;
            res.status = STATUS_CLAMPED;
        end
        else if (mag == PosInf)
        begin
            res.root_bits = PosInf;
            res.status = STATUS_INVALID;
        end
        else
        begin
            bexp = x[62:52];
            if (bexp == 11'd0)
            begin
                m = {2'b00, x[51:0]};
                e = -1074;
                while (m[52] == 1'b0)
                begin
                    m = m << 1;
                    e = e - 1;
                end
            end
            else
            begin
                m = {2'b01, x[51:0]};
                e = int'(bexp) - 1075;
            end
            if (e % 2 != 0)
            begin
                m = m << 1;
                e = e - 1;
            end
            radicand = {m, 54'd0};
            q = '0;
            rem = '0;
            for (int i = 53; i >= 0; i--)
            begin
                rem = {rem[55:0], radicand[2*i+1], radicand[2*i]};
                trial = {2'b00, q, 2'b01};
                if (rem >= trial)
                begin
                    rem = rem - trial;
                    q = {q[52:0], 1'b1};
                end
                else
                begin
                    q = {q[52:0], 1'b0};
                end
            end
            mant = q[53:1];
            f = e / 2 - 26;
            if (q[0] && (rem != 0 || mant[0]))
            begin
                {q[0], mant} = {1'b0, mant} + 54'd1;
                if (q[0])
                begin
                    mant = 53'h10_0000_0000_0000;
                    f = f + 1;
                end
            end
            res.root_bits = {1'b0, 11'(f + 1075), mant[51:0]};
            res.status = STATUS_NORMAL;
        end
        return res;
    endfunction

    // Random operand, biased toward normals, with subnormals and specials.
    function automatic logic [63:0] random_operand();
        logic [63:0] x;
        int          pick;
        x = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            x[62:52] = 11'd0;
        end
        else if (pick < 12)
        begin
            x[62:52] = 11'h7FF;
            if ($urandom_range(0, 1) == 0)
                x[51:0] = '0;
        end
        else if (pick < 15)
        begin
            x[62:0] = '0;
        end
        else if (pick < 70)
        begin
            x[63] = 1'b0;
        end
        if (pick >= 15 && pick < 70 && $urandom_range(0, 3) == 0)
            x[51:0] = '0;
        return x;
    endfunction

    // Offer one beat; valid stays high into the next call unless an idle gap drops it.
    task automatic send_operand(input logic [63:0] x, input root_result_t answer,
                                input logic fixed);
        root_result_t expected;
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.operand_bits <= x;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        expected = fixed ? answer : predict_root(x);
        pending_roots.push_back(expected);
        beats_in++;
        if (x[62:52] == 11'h7FF || x[63] || x[62:0] == '0)
            special_count++;
        else if (x[62:52] == 11'd0)
            subnormal_count++;
        @(negedge clk);
    endtask

    // Stimulus: directed table first, then random operands.
    initial
    begin
        vector_t     vectors[$];
        root_result_t none;
        none = '0;
        in_ch.valid = 1'b0;
        in_ch.operand_bits = '0;
        vectors = '{
            '{64'h0000_0000_0000_0000, 1'b1, '{64'd0, STATUS_CLAMPED}},
            '{64'h8000_0000_0000_0000, 1'b1, '{64'd0, STATUS_CLAMPED}},
            '{64'hBFF0_0000_0000_0000, 1'b1, '{64'd0, STATUS_CLAMPED}},
            '{64'hFFF0_0000_0000_0000, 1'b1, '{64'd0, STATUS_CLAMPED}},
            '{64'h8000_0000_0000_0001, 1'b1, '{64'd0, STATUS_CLAMPED}},
            '{64'hFFEF_FFFF_FFFF_FFFF, 1'b1, '{64'd0, STATUS_CLAMPED}},
            '{64'h7FF0_0000_0000_0000, 1'b1, '{PosInf, STATUS_INVALID}},
            '{64'h7FF8_0000_0000_0000, 1'b1, '{QuietNan, STATUS_INVALID}},
            '{64'h7FF0_0000_0000_0001, 1'b1, '{QuietNan, STATUS_INVALID}},
            '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{QuietNan, STATUS_INVALID}},
            '{64'hFFF8_0000_0000_0000, 1'b1, '{QuietNan, STATUS_INVALID}},
            '{64'h3FF0_0000_0000_0000, 1'b1, '{64'h3FF0_0000_0000_0000, STATUS_NORMAL}},
            '{64'h4010_0000_0000_0000, 1'b1, '{64'h4000_0000_0000_0000, STATUS_NORMAL}},
            '{64'h4000_0000_0000_0000, 1'b0, none},
            '{64'h0000_0000_0000_0001, 1'b0, none},
            '{64'h0000_0000_0000_0002, 1'b0, none},
            '{64'h000F_FFFF_FFFF_FFFF, 1'b0, none},
            '{64'h0008_0000_0000_0000, 1'b0, none},
            '{64'h0010_0000_0000_0000, 1'b0, none},
            '{64'h7FEF_FFFF_FFFF_FFFF, 1'b0, none},
            '{64'h3FEF_FFFF_FFFF_FFFF, 1'b0, none},
            '{64'h3FF0_0000_0000_0001, 1'b0, none},
            '{64'h5555_5555_5555_5555, 1'b0, none},
            '{64'h2AAA_AAAA_AAAA_AAAA, 1'b0, none}
        };
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        foreach (vectors[i])
            send_operand(vectors[i].operand_bits, vectors[i].answer, vectors[i].fixed);
        for (int n = 0; n < NumRandom; n++)
        begin
            // Drop idling for the tail of the run.
            if (n == NumRandom - 100)
                no_idle = 1'b1;
            send_operand(random_operand(), none, 1'b0);
        end
        in_ch.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Result side: random stall bursts, plus one long hold-off early on
    // while the sender keeps offering, so the block stalls its input.
    initial
    begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (beats_in == 40 && !hold_off)
            begin
                hold_off = 1'b1;
                out_ch.ready <= 1'b0;
                stall = 400;
                while (stall > 0)
                begin
                    @(negedge clk);
                    stall--;
                end
                out_ch.ready <= 1'b1;
            end
            else if (!no_idle && $urandom_range(0, 5) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9) - 1) @(negedge clk);
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Check each result beat against the oldest expectation.
    always @(posedge clk)
    begin
        root_result_t expected;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            beats_out++;
            if (pending_roots.size() == 0)
            begin
                $display("%0t: unexpected result root=%h status=%0d", $time,
                         out_ch.root_bits, out_ch.status);
                fail_count++;
            end
            else
            begin
                expected = pending_roots.pop_front();
                if (out_ch.root_bits !== expected.root_bits)
                begin
                    $display("%0t: root_bits expected %h actual %h", $time,
                             expected.root_bits, out_ch.root_bits);
                    fail_count++;
                end
                if (out_ch.status !== expected.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             expected.status, out_ch.status);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: count cycles with no beat on either side.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        @(posedge rst_n);
        while (!(stim_done && pending_roots.size() == 0) && idle_cycles < WatchLimit)
            @(posedge clk);
        if (idle_cycles >= WatchLimit)
        begin
            $display("%0t: timeout with %0d results pending", $time, pending_roots.size());
            $display("FAIL");
        end
        else
        begin
            repeat (DrainCycles) @(posedge clk);
            $display("Sent %0d operands (%0d special, %0d subnormal), checked %0d roots.",
                     beats_in, special_count, subnormal_count, beats_out);
            if (fail_count == 0 && pending_roots.size() == 0)
                $display("PASS");
            else
                $display("FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> sim.f
src/dsr_pkg.sv
src/dsr_if.sv
src/dsr_datapath.sv
src/dsr_control.sv
src/double_square_root.sv
src/dsr_checker.sv
tb/sv/double_square_root_tb.sv
